>>> src/psb_pkg.sv
// Shared types, constants and the pixel merge function of the page sprite blitter.
package psb_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int SCREEN_PAGES  = SCREEN_HEIGHT / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * SCREEN_PAGES;
  localparam int STORE_AW      = $clog2(STORE_BYTES);

  // Signed copies of the screen limits at the width of the position math.
  localparam logic signed [17:0] SCREEN_W_S = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] SCREEN_H_S = 18'(SCREEN_HEIGHT);
  localparam logic signed [17:0] SCREEN_P_S = 18'(SCREEN_PAGES);

  // Depth of the queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [2:0] MODE_OVERWRITE = 3'd0;
  localparam logic [2:0] MODE_OR        = 3'd1;
  localparam logic [2:0] MODE_ERASE     = 3'd2;
  localparam logic [2:0] MODE_EXT_MASK  = 3'd3;
  localparam logic [2:0] MODE_INT_MASK  = 3'd4;

  // Merge operations carried out by the back end.
  localparam logic [1:0] MRG_MASKED = 2'd0;
  localparam logic [1:0] MRG_OR     = 2'd1;
  localparam logic [1:0] MRG_ERASE  = 2'd2;

  typedef struct packed {
    logic               command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         sprite_width;
    logic [7:0]         sprite_height;
    logic [7:0]         src_column;
    logic [4:0]         src_page;
    logic [7:0]         image_byte;
    logic [7:0]         mask_byte;
    logic [2:0]         mode;
    logic [9:0]         read_address;
  } psb_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] bytes_written;
  } psb_out_t;

  // One classified job as it travels from the front to the back.
  typedef struct packed {
    logic                is_read;
    logic                rd_ok;
    logic                lo_en;
    logic                hi_en;
    logic [STORE_AW-1:0] lo_addr;
    logic [STORE_AW-1:0] hi_addr;
    logic [15:0]         img;
    logic [15:0]         msk;
    logic [1:0]          op;
  } psb_job_t;

  function automatic logic [7:0] merge_byte(input logic [7:0] old_b,
                                            input logic [7:0] img_b,
                                            input logic [7:0] msk_b,
                                            input logic [1:0] op);
    logic [7:0] res;
    unique case (op)
      MRG_OR:    res = old_b | img_b;
      MRG_ERASE: res = old_b & ~img_b;
      default:   res = (old_b & ~msk_b) | img_b;
    endcase
    return res;
  endfunction

endpackage

>>> src/psb_front.sv
// Front end: accepts input words and turns them into store addresses, masks and enables.
module psb_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  psb_pkg::psb_in_t  in_data,
  input  logic              q_full,
  input  logic              clearing,
  output logic              push,
  output psb_pkg::psb_job_t job
);
  import psb_pkg::*;

  logic signed [17:0] x_e, y_e, x_end, y_end, sx, base, base_hi;
  logic [2:0]  yoff;
  logic        mode_ok, size_ok, on_screen, src_ok, draw_ok, sx_ok, lo_ok, hi_ok;
  logic [15:0] msk_src;

  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    x_e     = {{2{in_data.pos_x[15]}}, in_data.pos_x};
    y_e     = {{2{in_data.pos_y[15]}}, in_data.pos_y};
    x_end   = x_e + $signed({10'd0, in_data.sprite_width});
    y_end   = y_e + $signed({10'd0, in_data.sprite_height});
    sx      = x_e + $signed({10'd0, in_data.src_column});
    // The top edge rounded down to a page is an arithmetic shift by three.
    base    = $signed({{5{in_data.pos_y[15]}}, in_data.pos_y[15:3]})
              + $signed({13'd0, in_data.src_page});
    base_hi = base + 18'sd1;
    yoff    = in_data.pos_y[2:0];

    mode_ok   = in_data.mode <= MODE_INT_MASK;
    size_ok   = (in_data.sprite_width != 8'd0) && (in_data.sprite_height != 8'd0);
    on_screen = (x_end > 18'sd0) && (x_e < SCREEN_W_S) &&
                (y_end > 18'sd0) && (y_e < SCREEN_H_S);
    src_ok    = (in_data.src_column < in_data.sprite_width) &&
                ({1'b0, in_data.src_page, 3'b000} < {1'b0, in_data.sprite_height});
    draw_ok   = (in_data.command == CMD_DRAW) && mode_ok && size_ok && on_screen && src_ok;

    sx_ok = (sx >= 18'sd0) && (sx < SCREEN_W_S);
    lo_ok = (base >= 18'sd0) && (base < SCREEN_P_S);
    hi_ok = (yoff != 3'd0) && (base_hi >= 18'sd0) && (base_hi < SCREEN_P_S);

    msk_src = (in_data.mode == MODE_OVERWRITE) ? 16'h00FF : {8'd0, in_data.mask_byte};

    job.is_read = (in_data.command == CMD_READ);
    job.rd_ok   = 32'(in_data.read_address) < STORE_BYTES;
    job.lo_en   = draw_ok && sx_ok && lo_ok;
    job.hi_en   = draw_ok && sx_ok && hi_ok;
    if (job.is_read) begin
      job.lo_addr = STORE_AW'(in_data.read_address);
    end else begin
      job.lo_addr = STORE_AW'(32'(base) * SCREEN_WIDTH + 32'(sx));
    end
    job.hi_addr = STORE_AW'(32'(base_hi) * SCREEN_WIDTH + 32'(sx));
    job.img     = {8'd0, in_data.image_byte} << yoff;
    job.msk     = msk_src << yoff;
    unique case (in_data.mode)
      MODE_OR:    job.op = MRG_OR;
      MODE_ERASE: job.op = MRG_ERASE;
      default:    job.op = MRG_MASKED;
    endcase
  end

endmodule

>>> src/psb_queue.sv
// Short job queue between the front end and the back end.
module psb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  psb_pkg::psb_job_t push_job,
  input  logic              pop,
  output psb_pkg::psb_job_t head_job,
  output logic              full,
  output logic              empty
);
  import psb_pkg::*;

  psb_job_t           slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full     = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> src/psb_back.sv
// Back end: frame memory, clearing pass and the read-modify-write sequencer.
module psb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  psb_pkg::psb_job_t q_job,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_stall,
  output psb_pkg::psb_out_t out_data
);
  import psb_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LO    = 2'd2;
  localparam logic [1:0] ST_HI    = 2'd3;

  logic [7:0]          mem [STORE_BYTES];
  logic [7:0]          rd_q;
  logic                we;
  logic [STORE_AW-1:0] wa, ra;
  logic [7:0]          wd;

  logic [1:0]          st_r, st_nxt;
  logic [STORE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  psb_job_t            cur_r, cur_nxt;
  logic                out_valid_r, out_valid_nxt;
  psb_out_t            out_data_r, out_data_nxt;

  assign clearing  = st_r == ST_CLEAR;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    st_nxt        = st_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    wa            = cur_r.lo_addr;
    wd            = '0;
    ra            = cur_r.hi_addr;
    unique case (st_r)
      ST_CLEAR: begin
        we          = 1'b1;
        wa          = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == STORE_AW'(STORE_BYTES - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // Start a job only when the output register will be free at its end.
        ra = q_job.lo_addr;
        if (!q_empty && (!out_valid_r || !out_stall)) begin
          q_pop   = 1'b1;
          cur_nxt = q_job;
          st_nxt  = ST_LO;
        end
      end
      ST_LO: begin
        if (cur_r.is_read) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.read_data     = cur_r.rd_ok ? rd_q : 8'd0;
          out_data_nxt.bytes_written = 2'd0;
          st_nxt                     = ST_IDLE;
        end else begin
          we = cur_r.lo_en;
          wa = cur_r.lo_addr;
          wd = merge_byte(rd_q, cur_r.img[7:0], cur_r.msk[7:0], cur_r.op);
          if (cur_r.hi_en) begin
            st_nxt = ST_HI;
          end else begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.read_data     = 8'd0;
            out_data_nxt.bytes_written = {1'b0, cur_r.lo_en};
            st_nxt                     = ST_IDLE;
          end
        end
      end
      ST_HI: begin
        we                         = 1'b1;
        wa                         = cur_r.hi_addr;
        wd                         = merge_byte(rd_q, cur_r.img[15:8], cur_r.msk[15:8],
                                                cur_r.op);
        out_valid_nxt              = 1'b1;
        out_data_nxt.read_data     = 8'd0;
        out_data_nxt.bytes_written = {1'b0, cur_r.lo_en} + 2'd1;
        st_nxt                     = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

endmodule

>>> src/page_sprite_blitter_core.sv
// Top level of the page sprite blitter: front end, job queue and back end.
// Flow: an accepted word is queued; the back end pops it in ST_IDLE, answers a read or
// writes the low byte in ST_LO and, for a draw that spans two pages, the high byte in
// ST_HI, then registers the result on out_valid. The back end starts a new job only after
// the last one is through this read-modify-write sequence on the single frame memory.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the 1024-byte store,
// with in_stall held high until it is done.
module page_sprite_blitter_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  psb_pkg::psb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output psb_pkg::psb_out_t out_data
);
  import psb_pkg::*;

  // Job handoff between the front end and the queue.
  logic     push;
  psb_job_t push_job;

  // Queue status and head, seen by both sides.
  logic     q_full, q_empty, q_pop;
  psb_job_t head_job;

  // The back end owns the frame memory and reports its clearing pass so that the
  // front end holds off new words until the store reads as all zero.
  logic     clearing;

  // The front end classifies every word in the cycle it is accepted: clipping,
  // page split by the vertical offset, target addresses and shifted masks.
  psb_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .job      (push_job)
  );

  // The queue lets the front keep taking words while the back is busy with
  // memory cycles or waiting on a stalled output.
  psb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // The back end answers a read from the store, or for a draw reads each target byte,
  // merges the sprite bits and writes it back; then it places the result word in its output register.
  psb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
